// ===== hw/rtl/hrlp_pkg.sv =====
package hrlp_pkg;

  localparam int unsigned MAX_RES    = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_PATH = 2'd0;
  localparam logic [1:0] KIND_ARG  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  localparam logic [1:0] METH_GET  = 2'd0;
  localparam logic [1:0] METH_POST = 2'd1;
  localparam logic [1:0] METH_HEAD = 2'd2;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_SL  = 8'h2f;
  localparam logic [7:0] CH_QM  = 8'h3f;

  typedef enum logic [3:0] {
    PH_LEAD,
    PH_METHOD,
    PH_GAP1,
    PH_URL,
    PH_ESC1,
    PH_ESC2,
    PH_GAP2,
    PH_VERSION,
    PH_TRAIL,
    PH_DONE,
    PH_FAIL
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [2:0] method_count;
    logic [2:0] method_match;
    logic [1:0] method_found;
    logic       in_arguments;
    logic [7:0] escape_first_digit;
    logic [2:0] version_index;
    logic [3:0] major_digit;
    logic [3:0] minor_digit;
  } st_t;

  localparam st_t ST_RESET = '{
    phase:              PH_LEAD,
    method_count:       3'd0,
    method_match:       3'b111,
    method_found:       2'd0,
    in_arguments:       1'b0,
    escape_first_digit: 8'd0,
    version_index:      3'd0,
    major_digit:        4'd0,
    minor_digit:        4'd0
  };

  typedef struct packed {
    logic [7:0] octet;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [1:0] method_code;
    logic [3:0] version_major;
    logic [3:0] version_minor;
    logic       run_end;
  } out_word_t;

  function automatic logic is_gap(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5a);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic logic [2:0] word_len(input logic [1:0] k);
    return (k == METH_GET) ? 3'd3 : 3'd4;
  endfunction

  function automatic logic [7:0] word_char(input logic [1:0] k, input logic [1:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      METH_GET: begin
        case (i)
          2'd0:    r = 8'h47;
          2'd1:    r = 8'h45;
          2'd2:    r = 8'h54;
          default: r = 8'h00;
        endcase
      end
      METH_POST: begin
        case (i)
          2'd0:    r = 8'h50;
          2'd1:    r = 8'h4f;
          2'd2:    r = 8'h53;
          default: r = 8'h54;
        endcase
      end
      METH_HEAD: begin
        case (i)
          2'd0:    r = 8'h48;
          2'd1:    r = 8'h45;
          2'd2:    r = 8'h41;
          default: r = 8'h44;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // lower-case letters of the version prefix
  function automatic logic [7:0] ver_char(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = 8'h68;
      2'd1:    r = 8'h74;
      2'd2:    r = 8'h74;
      default: r = 8'h70;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/hrlp_step.sv =====
module hrlp_step
  import hrlp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  word_i,
  input  logic      fire_i,
  output out_word_t res_o [MAX_RES],
  output logic [1:0] n_o
);

  st_t        st_q, st_d;
  st_t        s;
  logic [7:0] c;
  logic [1:0] n;
  logic       do_url, do_ver, do_fail;
  logic [4:0] hq, hw, hc;
  logic [2:0] mcnt;
  logic [2:0] vi;
  logic       vok;
  logic [1:0] dkind;
  out_word_t  res [MAX_RES];

  function automatic out_word_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                       input st_t st);
    out_word_t r;
    r.kind          = kind;
    r.data_byte     = (kind == KIND_PATH || kind == KIND_ARG) ? data : 8'd0;
    r.method_code   = (kind != KIND_BAD) ? st.method_found : 2'd0;
    r.version_major = (kind == KIND_DONE) ? st.major_digit : 4'd0;
    r.version_minor = (kind == KIND_DONE) ? st.minor_digit : 4'd0;
    r.run_end       = 1'b0;
    return r;
  endfunction

  always_comb begin
    s       = word_i.restart ? ST_RESET : st_q;
    st_d    = s;
    c       = word_i.octet;
    n       = 2'd0;
    do_url  = 1'b0;
    do_ver  = 1'b0;
    do_fail = 1'b0;
    hc      = hex_value(c);
    hq      = hex_value(s.escape_first_digit);
    hw      = hc;
    mcnt    = s.method_count;
    vi      = 3'd0;
    vok     = 1'b0;
    for (int k = 0; k < MAX_RES; k++) res[k] = '0;
    dkind   = s.in_arguments ? KIND_ARG : KIND_PATH;

    if (s.phase == PH_DONE || s.phase == PH_FAIL) begin
      st_d = s;
    end else if (c == CH_NUL) begin
      do_fail = 1'b1;
    end else begin
      case (s.phase)
        PH_LEAD: begin
          if (is_gap(c) || c == CH_LF) begin
            st_d = s;
          end else if (!is_upper(c)) begin
            do_fail = 1'b1;
          end else begin
            for (int k = 0; k < 3; k++) begin
              if (mcnt >= word_len(2'(k)) || word_char(2'(k), mcnt[1:0]) != c)
                st_d.method_match[k] = 1'b0;
            end
            if (mcnt < 3'd7) st_d.method_count = mcnt + 3'd1;
            st_d.phase = PH_METHOD;
          end
        end
        PH_METHOD: begin
          if (is_upper(c)) begin
            for (int k = 0; k < 3; k++) begin
              if (mcnt >= word_len(2'(k)) || word_char(2'(k), mcnt[1:0]) != c)
                st_d.method_match[k] = 1'b0;
            end
            if (mcnt < 3'd7) st_d.method_count = mcnt + 3'd1;
          end else begin
            if (mcnt == 3'd3 && s.method_match[0]) st_d.method_found = METH_GET;
            else if (mcnt == 3'd4 && s.method_match[1]) st_d.method_found = METH_POST;
            else if (mcnt == 3'd4 && s.method_match[2]) st_d.method_found = METH_HEAD;
            else do_fail = 1'b1;
            if (!do_fail) begin
              st_d.phase = PH_GAP1;
              do_url     = !is_gap(c);
            end
          end
        end
        PH_GAP1: do_url = !is_gap(c);
        PH_URL:  do_url = 1'b1;
        PH_ESC1: begin
          if (hc[4]) begin
            st_d.escape_first_digit = c;
            st_d.phase              = PH_ESC2;
          end else begin
            res[n] = mk_res(dkind, CH_PCT, st_d);
            n      = n + 2'd1;
            do_url = 1'b1;
          end
        end
        PH_ESC2: begin
          if (hq[4] && hw[4]) begin
            if ({hq[3:0], hw[3:0]} == 8'd0) begin
              do_fail = 1'b1;
            end else begin
              res[n]     = mk_res(dkind, {hq[3:0], hw[3:0]}, st_d);
              n          = n + 2'd1;
              st_d.phase = PH_URL;
            end
          end else begin
            res[n] = mk_res(dkind, CH_PCT, st_d);
            n      = n + 2'd1;
            res[n] = mk_res(dkind, s.escape_first_digit, st_d);
            n      = n + 2'd1;
            do_url = 1'b1;
          end
        end
        PH_GAP2: begin
          if (!is_gap(c)) begin
            st_d.phase         = PH_VERSION;
            st_d.version_index = 3'd0;
            do_ver             = 1'b1;
          end
        end
        PH_VERSION: do_ver = 1'b1;
        PH_TRAIL: begin
          if (is_gap(c)) begin
            st_d = s;
          end else if (c == CH_LF) begin
            res[n]     = mk_res(KIND_DONE, 8'd0, st_d);
            n          = n + 2'd1;
            st_d.phase = PH_DONE;
          end else begin
            do_fail = 1'b1;
          end
        end
        default: st_d = s;
      endcase
    end

    if (do_url) begin
      st_d.phase = PH_URL;
      if (is_gap(c)) begin
        st_d.phase = PH_GAP2;
      end else if (c == CH_LF) begin
        do_fail = 1'b1;
      end else if (c == CH_PCT) begin
        st_d.phase = PH_ESC1;
      end else if (c == CH_QM && !st_d.in_arguments) begin
        st_d.in_arguments = 1'b1;
      end else begin
        res[n] = mk_res(st_d.in_arguments ? KIND_ARG : KIND_PATH, c, st_d);
        n      = n + 2'd1;
      end
    end

    if (do_ver) begin
      vi = st_d.version_index;
      if (vi == 3'd5 || vi == 3'd7) begin
        vok = (c >= 8'h30) && (c <= 8'h39);
        if (vok && vi == 3'd5) st_d.major_digit = 4'(c - 8'h30);
        if (vok && vi == 3'd7) st_d.minor_digit = 4'(c - 8'h30);
      end else if (vi <= 3'd3) begin
        vok = ((c | 8'h20) == ver_char(vi[1:0]));
      end else if (vi == 3'd4) begin
        vok = (c == CH_SL);
      end else begin
        vok = (c == CH_DOT);
      end
      if (!vok) do_fail = 1'b1;
      else if (vi == 3'd7) st_d.phase = PH_TRAIL;
      else st_d.version_index = vi + 3'd1;
    end

    if (do_fail) begin
      res[n]     = mk_res(KIND_BAD, 8'd0, st_d);
      n          = n + 2'd1;
      st_d.phase = PH_FAIL;
    end

    if (n != 2'd0) res[n - 2'd1].run_end = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RESET;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

  assign res_o = res;
  assign n_o   = n;

endmodule

// ===== hw/rtl/hrlp_queue.sv =====
module hrlp_queue
  import hrlp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [1:0] push_n_i,
  input  out_word_t  push_word_i [MAX_RES],
  output logic [2:0] free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  out_word_t  q_q [QUEUE_DEPTH];
  out_word_t  q_d [QUEUE_DEPTH];
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] rem;
  logic [2:0] off;
  logic [2:0] add;
  logic       pop;

  assign pop = (cnt_q != 3'd0) && !out_stall_i;
  assign rem = cnt_q - {2'b00, pop};
  assign add = push_i ? {1'b0, push_n_i} : 3'd0;

  always_comb begin
    off = 3'd0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && i < QUEUE_DEPTH - 1) q_d[i] = q_q[(i + 1) % QUEUE_DEPTH];
      else q_d[i] = q_q[i];
      off = 3'(i) - rem;
      if (3'(i) >= rem && off < add) q_d[i] = push_word_i[off[1:0]];
    end
    cnt_d = rem + add;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign free_o      = 3'(QUEUE_DEPTH) - cnt_q;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_word_o  = q_q[0];

endmodule

// ===== hw/rtl/http_request_line_parser.sv =====
// channel  dir  handshake                 word
// in       in   in_valid_i / in_stall_o   in_word_i  (octet, restart)
// out      out  out_valid_o / out_stall_i out_word_o (kind, data_byte, method_code,
//                                                     version_major, version_minor, run_end)
// a byte is held in the input register once taken and is parsed from there in a single state step
// each byte gives zero to three words, queued four deep; one word leaves per cycle unless out_stall_i is high
// sustained rate is one byte per cycle while each byte gives at most one word and out_stall_i is low
// a byte waits in the input register until the queue has room for all its words
// reset clears parser state and the queue; no clearing pass
module http_request_line_parser
  import hrlp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  in_word_t   in_q;
  logic       in_vld_q;
  logic       accept;
  logic       fire;
  logic [1:0] n;
  logic [2:0] free;
  out_word_t  res [MAX_RES];

  assign fire       = in_vld_q && ({1'b0, n} <= free);
  assign in_stall_o = in_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept || (in_vld_q && !fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
  end

  hrlp_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (in_q),
    .fire_i (fire),
    .res_o  (res),
    .n_o    (n)
  );

  hrlp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .push_n_i    (n),
    .push_word_i (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== hw/rtl/hrlp_checker.sv =====
module hrlp_checker
  import hrlp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_DONE || out_word_o.kind == KIND_BAD)
    |-> out_word_o.data_byte == 8'd0 && out_word_o.run_end)
    else $error("status word carries data or is not last");

  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == KIND_BAD
    |-> out_word_o.method_code == 2'd0 && out_word_o.version_major == 4'd0
        && out_word_o.version_minor == 4'd0)
    else $error("bad request word has nonzero fields");

  a_url_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_PATH || out_word_o.kind == KIND_ARG)
    |-> out_word_o.version_major == 4'd0 && out_word_o.version_minor == 4'd0
        && out_word_o.data_byte != 8'd0 && out_word_o.method_code != 2'd3)
    else $error("url word fields out of range");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

// ===== bench/http_request_line_parser_tb.sv =====
`timescale 1ns / 100ps

module http_request_line_parser_tb;
  import hrlp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES  = 80;

  typedef logic [7:0] octets_t[$];

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  // parser state as predicted
  phase_e     pr_phase;
  logic [2:0] pr_mcount;
  logic [2:0] pr_mmatch;
  logic [1:0] pr_method;
  logic       pr_args;
  logic [7:0] pr_esc_hi;
  logic [2:0] pr_vidx;
  logic [3:0] pr_major;
  logic [3:0] pr_minor;

  string meth_names[3] = '{"GET", "POST", "HEAD"};
  string ver_prefix    = "http";
  string hex_chars     = "0123456789abcdefABCDEF";

  out_word_t   expected_words[$];
  out_word_t   byte_words[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned sent_bytes = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  bit          send_idle  = 1'b1;
  bit          recv_idle  = 1'b1;

  http_request_line_parser DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_word_i,
    .out_valid_o,
    .out_stall_i,
    .out_word_o
  );

  always #5 clk_i = ~clk_i;

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR;
  endfunction

  function automatic bit is_capital(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    return -1;
  endfunction

  function automatic logic [1:0] url_kind();
    return pr_args ? KIND_ARG : KIND_PATH;
  endfunction

  task automatic predictor_reset();
    pr_phase  = PH_LEAD;
    pr_mcount = 3'd0;
    pr_mmatch = 3'b111;
    pr_method = METH_GET;
    pr_args   = 1'b0;
    pr_esc_hi = 8'h00;
    pr_vidx   = 3'd0;
    pr_major  = 4'd0;
    pr_minor  = 4'd0;
  endtask

  task automatic emit_word(input logic [1:0] kind, input logic [7:0] data);
    out_word_t w;
    w.kind          = kind;
    w.data_byte     = (kind == KIND_PATH || kind == KIND_ARG) ? data : 8'h00;
    w.method_code   = (kind == KIND_BAD) ? 2'd0 : pr_method;
    w.version_major = (kind == KIND_DONE) ? pr_major : 4'd0;
    w.version_minor = (kind == KIND_DONE) ? pr_minor : 4'd0;
    w.run_end       = 1'b0;
    byte_words.push_back(w);
  endtask

  task automatic bad_request();
    emit_word(KIND_BAD, 8'h00);
    pr_phase = PH_FAIL;
  endtask

  task automatic take_letter(input logic [7:0] c);
    for (int k = 0; k < 3; k++) begin
      if (pr_mcount >= meth_names[k].len() || meth_names[k][pr_mcount] != c) pr_mmatch[k] = 1'b0;
    end
    if (pr_mcount < 3'd7) pr_mcount = pr_mcount + 3'd1;
  endtask

  task automatic url_char(input logic [7:0] c);
    pr_phase = PH_URL;
    if (is_blank(c)) pr_phase = PH_GAP2;
    else if (c == CH_LF) bad_request();
    else if (c == CH_PCT) pr_phase = PH_ESC1;
    else if (c == CH_QM && !pr_args) pr_args = 1'b1;
    else emit_word(url_kind(), c);
  endtask

  task automatic close_method(input logic [1:0] m, input logic [7:0] c);
    pr_method = m;
    pr_phase  = PH_GAP1;
    if (!is_blank(c)) url_char(c);
  endtask

  task automatic version_char(input logic [7:0] c);
    bit ok;
    case (pr_vidx)
      3'd0, 3'd1, 3'd2, 3'd3: ok = ((c | 8'h20) == ver_prefix[pr_vidx]);
      3'd4: ok = (c == CH_SL);
      3'd6: ok = (c == CH_DOT);
      default: begin
        ok = (c >= "0" && c <= "9");
        if (ok && pr_vidx == 3'd5) pr_major = 4'(c - 8'h30);
        else if (ok) pr_minor = 4'(c - 8'h30);
      end
    endcase
    if (!ok) bad_request();
    else if (pr_vidx == 3'd7) pr_phase = PH_TRAIL;
    else pr_vidx = pr_vidx + 3'd1;
  endtask

  task automatic predict_byte(input in_word_t w);
    logic [7:0] c;
    int         hi;
    int         lo;
    out_word_t  last;
    c = w.octet;
    byte_words.delete();
    if (w.restart) predictor_reset();
    if (pr_phase != PH_DONE && pr_phase != PH_FAIL) begin
      if (c == CH_NUL) begin
        bad_request();
      end else begin
        case (pr_phase)
          PH_LEAD: begin
            if (!is_blank(c) && c != CH_LF) begin
              if (!is_capital(c)) bad_request();
              else begin
                take_letter(c);
                pr_phase = PH_METHOD;
              end
            end
          end
          PH_METHOD: begin
            if (is_capital(c)) take_letter(c);
            else if (pr_mcount == 3'd3 && pr_mmatch[METH_GET]) close_method(METH_GET, c);
            else if (pr_mcount == 3'd4 && pr_mmatch[METH_POST]) close_method(METH_POST, c);
            else if (pr_mcount == 3'd4 && pr_mmatch[METH_HEAD]) close_method(METH_HEAD, c);
            else bad_request();
          end
          PH_GAP1: begin
            if (!is_blank(c)) url_char(c);
          end
          PH_URL: url_char(c);
          PH_ESC1: begin
            if (hex_nibble(c) >= 0) begin
              pr_esc_hi = c;
              pr_phase  = PH_ESC2;
            end else begin
              emit_word(url_kind(), CH_PCT);
              url_char(c);
            end
          end
          PH_ESC2: begin
            hi = hex_nibble(pr_esc_hi);
            lo = hex_nibble(c);
            if (lo < 0) begin
              emit_word(url_kind(), CH_PCT);
              emit_word(url_kind(), pr_esc_hi);
              url_char(c);
            end else if (((hi << 4) + lo) == 0) begin
              bad_request();
            end else begin
              emit_word(url_kind(), 8'((hi << 4) + lo));
              pr_phase = PH_URL;
            end
          end
          PH_GAP2: begin
            if (!is_blank(c)) begin
              pr_phase = PH_VERSION;
              pr_vidx  = 3'd0;
              version_char(c);
            end
          end
          PH_VERSION: version_char(c);
          PH_TRAIL: begin
            if (c == CH_LF) begin
              emit_word(KIND_DONE, 8'h00);
              pr_phase = PH_DONE;
            end else if (!is_blank(c)) begin
              bad_request();
            end
          end
          default: ;
        endcase
      end
    end
    if (byte_words.size() > 0) begin
      last = byte_words.pop_back();
      last.run_end = 1'b1;
      byte_words.push_back(last);
    end
    foreach (byte_words[i]) expected_words.push_back(byte_words[i]);
  endtask

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 2))
      0: return CH_SP;
      1: return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    return hex_chars[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'h7e)); while (c == CH_PCT);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  function automatic octets_t random_request();
    octets_t     r;
    int unsigned m;
    repeat ($urandom_range(0, 2)) r.push_back(($urandom_range(0, 3) == 0) ? CH_LF : blank_byte());
    m = $urandom_range(0, 9);
    if (m < 9) begin
      for (int i = 0; i < meth_names[m / 3].len(); i++) r.push_back(meth_names[m / 3][i]);
    end else begin
      repeat ($urandom_range(1, 5)) r.push_back(8'($urandom_range(8'h41, 8'h5a)));
    end
    if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 2)) r.push_back(blank_byte());
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        5: r.push_back(CH_QM);
        6, 7: begin
          r.push_back(CH_PCT);
          r.push_back(hex_char());
          r.push_back(hex_char());
        end
        8: begin
          r.push_back(CH_PCT);
          if ($urandom_range(0, 1) == 1) r.push_back(hex_char());
          r.push_back(non_hex_char());
        end
        9: r.push_back(8'($urandom_range(8'h80, 8'hff)));
        default: r.push_back(plain_char());
      endcase
    end
    repeat ($urandom_range(1, 2)) r.push_back(blank_byte());
    for (int i = 0; i < 4; i++) begin
      r.push_back(ver_prefix[i] ^ (($urandom_range(0, 1) == 1) ? 8'h20 : 8'h00));
    end
    r.push_back(CH_SL);
    r.push_back(8'h30 + 8'($urandom_range(0, 9)));
    r.push_back(CH_DOT);
    r.push_back(8'h30 + 8'($urandom_range(0, 9)));
    repeat ($urandom_range(0, 2)) r.push_back(blank_byte());
    r.push_back(CH_LF);
    if ($urandom_range(0, 4) == 0) r[$urandom_range(0, r.size() - 1)] = 8'($urandom);
    if ($urandom_range(0, 3) == 0) r.push_back(plain_char());
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] octet, input logic restart);
    in_word_t    w;
    int unsigned n;
    w.octet   = octet;
    w.restart = restart;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(w);
    sent_bytes++;
    if (send_idle && $urandom_range(0, 2) == 0) begin
      n = idle_len();
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_text(input string s, input logic restart);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], restart && i == 0);
  endtask

  task automatic send_request(input octets_t req);
    foreach (req[i]) send_byte(req[i], i == 0);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected word", got, 0);
    end else begin
      want = expected_words.pop_front();
      if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
      if (got.data_byte !== want.data_byte) report_mismatch("data_byte", got.data_byte, want.data_byte);
      if (got.method_code !== want.method_code)
        report_mismatch("method_code", got.method_code, want.method_code);
      if (got.version_major !== want.version_major)
        report_mismatch("version_major", got.version_major, want.version_major);
      if (got.version_minor !== want.version_minor)
        report_mismatch("version_minor", got.version_minor, want.version_minor);
      if (got.run_end !== want.run_end) report_mismatch("run_end", got.run_end, want.run_end);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_word(out_word_o);
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (recv_idle && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = idle_len() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk_i) cycles++;
    $display("FAIL http_request_line_parser");
    $finish;
  end

  // whitespace, escapes, arguments and broken escapes in one line
  task automatic test_url_decoding();
    send_byte(CH_SP, 1'b1);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_text("GET/a%41?b?%2g%%7e%z", 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("%2 HTTP/1.1", 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte("x", 1'b0);
    stop_sending();
  endtask

  task automatic test_methods_and_versions();
    send_text("POST", 1'b1);
    send_byte(CH_TAB, 1'b0);
    send_text("/ hTtP/9.0", 1'b0);
    send_byte(CH_LF, 1'b0);
    send_text("HEAD /%7F?%80 HTTP/0.9 ", 1'b1);
    send_byte(CH_LF, 1'b0);
    stop_sending();
  endtask

  task automatic test_bad_requests();
    send_text("HEAD /%00", 1'b1);
    send_text("GET /x", 1'b1);
    send_byte(CH_LF, 1'b0);
    send_text("GET", 1'b1);
    send_byte(CH_LF, 1'b0);
    send_text("G", 1'b1);
    send_byte(CH_NUL, 1'b0);
    send_text("PUT /", 1'b1);
    send_text("get", 1'b1);
    send_text("GET/ HTTP/1.1x", 1'b1);
    send_text("GET/ HTTP-", 1'b1);
    stop_sending();
  endtask

  task automatic test_random_requests(input int unsigned budget);
    int unsigned first;
    first = sent_bytes;
    while (sent_bytes - first < budget) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom));
      end else begin
        send_request(random_request());
      end
    end
    stop_sending();
  endtask

  task automatic test_back_to_back();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (1) send_request(random_request());
    stop_sending();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_receiver_hold();
    send_idle = 1'b0;
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    send_text("GET /", 1'b1);
    repeat (8) send_byte(plain_char(), 1'b0);
    send_text(" HTTP/1.0", 1'b0);
    send_byte(CH_LF, 1'b0);
    stop_sending();
    send_idle = 1'b1;
  endtask

  initial begin
    predictor_reset();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_url_decoding();
    test_methods_and_versions();
    test_bad_requests();
    test_random_requests(10);
    test_back_to_back();
    test_receiver_hold();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_words.size() != 0) report_mismatch("words never delivered", expected_words.size(), 0);
    if (mismatches == 0) begin
      $display("PASS http_request_line_parser");
    end else begin
      $display("FAIL http_request_line_parser");
    end
    $finish;
  end

endmodule
